// ----- src/psd_pkg.sv -----
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants for the pedometer step detector: field widths,
// reset values, controller commands and datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

  // Field widths.
  localparam int unsigned AccelW  = 16;
  localparam int unsigned LevelW  = 24;
  localparam int unsigned TotalW  = 32;
  localparam int unsigned WinW    = 8;
  localparam int unsigned GapW    = 8;
  localparam int unsigned HystW   = 11;
  localparam int unsigned RootW   = 32;
  localparam int unsigned MagW    = 16;
  localparam int unsigned FsumW   = 28;
  localparam int unsigned RecipW  = 28;
  localparam int unsigned ProdW   = FsumW + RecipW;
  localparam int unsigned RecipSh = 31;
  localparam int unsigned InDataW = 48;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned CntW    = 4;

  // Level reset value, 9.8 in unsigned Q8.16.
  localparam logic [LevelW-1:0] LevelReset = 24'd642253;

  // Reciprocal of ten, ceil(2^31 / 10); exact for every dividend below 2^30.
  localparam logic [RecipW-1:0] RecipTen = 28'd214748365;

  // First bit weight of the square root search.
  localparam logic [RootW-1:0] RootBitInit = 32'h4000_0000;

  // Last phase counter value of each iterative phase.
  localparam logic [CntW-1:0] SquareLast = 4'd2;
  localparam logic [CntW-1:0] RootLast   = 4'd15;

  localparam logic [GapW-1:0] GapMax = 8'd255;

  // Configuration register reset values.
  localparam logic [WinW-1:0]  WindowLenReset  = 8'd50;
  localparam logic [GapW-1:0]  MinStepGapReset = 8'd12;
  localparam logic [HystW-1:0] HysteresisReset = 11'd77;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgWindowLen  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMinStepGap = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHysteresis = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;       // capture a sample and start the accumulator
    logic            square;     // add the square of one axis
    logic [1:0]      axis;       // axis for the square step
    logic            root;       // one square root iteration
    logic            fsum;       // form the filter numerator
    logic            fmul;       // multiply by the reciprocal of ten
    logic            level;      // update the filtered level
    logic            window;     // update window min, max and threshold
    logic            decide;     // step decision and result register load
  } psd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // result register can take a new result
  } psd_status_t;

endpackage

`default_nettype wire

// ----- src/psd_ctrl.sv -----
// ----------------------------------------------------------------------------
// psd_ctrl
// Sequencer for one sample: three square steps, sixteen square root
// iterations, the filter, the window update and the step decision.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  psd_pkg::psd_status_t status,
  output psd_pkg::psd_cmd_t   cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SQUARE = 8'b0000_0010,
    S_ROOT   = 8'b0000_0100,
    S_FSUM   = 8'b0000_1000,
    S_FMUL   = 8'b0001_0000,
    S_LEVEL  = 8'b0010_0000,
    S_WINDOW = 8'b0100_0000,
    S_DECIDE = 8'b1000_0000
  } state_t;

  state_t                   state, state_next;
  logic [psd_pkg::CntW-1:0] cnt, cnt_next;

  // State and phase counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        cmd.axis   = cnt[1:0];
        if (cnt == psd_pkg::SquareLast) begin
          cnt_next   = '0;
          state_next = S_ROOT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ROOT: begin
        cmd.root = 1'b1;
        if (cnt == psd_pkg::RootLast) begin
          cnt_next   = '0;
          state_next = S_FSUM;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_FSUM: begin
        cmd.fsum   = 1'b1;
        state_next = S_FMUL;
      end
      S_FMUL: begin
        cmd.fmul   = 1'b1;
        state_next = S_LEVEL;
      end
      S_LEVEL: begin
        cmd.level  = 1'b1;
        state_next = S_WINDOW;
      end
      S_WINDOW: begin
        cmd.window = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        // Hold here until the previous result has been taken.
        if (status.out_free) begin
          cmd.decide = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/psd_dp.sv -----
// ----------------------------------------------------------------------------
// psd_dp
// Datapath: sum of squares on one shared multiplier, bit-pair square root,
// divide-by-ten low-pass filter, window min/max tracking and the step
// decision, with the result register on the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_dp (
  input  wire                                   clk,
  input  wire                                   rst,
  input  psd_pkg::psd_cmd_t                     cmd,
  output psd_pkg::psd_status_t                  status,
  input  wire [psd_pkg::InDataW-1:0]            in_data,
  input  wire [psd_pkg::WinW-1:0]               window_len,
  input  wire [psd_pkg::GapW-1:0]               min_step_gap,
  input  wire [psd_pkg::HystW-1:0]              hysteresis,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [psd_pkg::OutDataW-1:0]          out_data
);

  localparam int unsigned AW = psd_pkg::AccelW;
  localparam int unsigned LW = psd_pkg::LevelW;

  // Sample and square root registers.
  logic signed [AW-1:0]          ax, ay, az;
  logic [psd_pkg::RootW-1:0]     rem, res, bitw;
  logic [psd_pkg::FsumW-1:0]     fsum;
  logic [psd_pkg::ProdW-1:0]     prod;

  // Detector state.
  logic [LW-1:0]                 level, thr, wmax, wmin;
  logic [psd_pkg::WinW-1:0]      wcount;
  logic [psd_pkg::GapW-1:0]      gap;
  logic                          armed;
  logic [psd_pkg::TotalW-1:0]    total;

  // Shared squaring multiplier on the selected axis.
  logic signed [AW-1:0]          sel;
  logic [AW:0]                   mag_abs;
  logic [2*AW+1:0]               sq;

  always_comb begin
    case (cmd.axis)
      2'd0:    sel = ax;
      2'd1:    sel = ay;
      default: sel = az;
    endcase
    mag_abs = sel[AW-1] ? (17'd0 - {sel[AW-1], sel}) : {1'b0, sel};
    sq      = mag_abs * mag_abs;
  end

  // Square root iteration.
  logic [psd_pkg::RootW-1:0] trial;
  logic                      take;

  assign trial = res + bitw;
  assign take  = (rem >= trial);

  // Filter numerator: magnitude in Q8.16 plus nine times the old level.
  logic [psd_pkg::FsumW-1:0] fsum_next;

  assign fsum_next = {4'd0, res[psd_pkg::MagW-1:0], 8'd0}
                   + {1'b0, level, 3'd0} + {4'd0, level};

  // Window update.
  logic [LW-1:0]            wmax_next, wmin_next;
  logic [psd_pkg::WinW-1:0] wcount_inc;
  logic [LW:0]              mid_sum;

  always_comb begin
    if (wcount == '0) begin
      wmax_next = level;
      wmin_next = level;
    end else begin
      wmax_next = (level > wmax) ? level : wmax;
      wmin_next = (level < wmin) ? level : wmin;
    end
    wcount_inc = wcount + 1'b1;
    mid_sum    = {1'b0, wmax_next} + {1'b0, wmin_next};
  end

  // Step decision against the threshold and hysteresis band.
  logic [psd_pkg::GapW-1:0]   gap_inc, gap_next;
  logic [LW:0]                band, upper, lower;
  logic                       above, below, step_hit, armed_next;
  logic [psd_pkg::TotalW-1:0] total_next;

  always_comb begin
    gap_inc    = (gap == psd_pkg::GapMax) ? gap : gap + 1'b1;
    band       = {6'd0, hysteresis, 8'd0};
    upper      = {1'b0, thr} + band;
    lower      = {1'b0, level} + band;
    above      = ({1'b0, level} > upper);
    below      = (lower < {1'b0, thr});
    // A rise while armed disarms; it counts only when the gap allows.
    step_hit   = armed && above && (gap_inc >= min_step_gap);
    gap_next   = step_hit ? '0 : gap_inc;
    total_next = step_hit ? total + 1'b1 : total;
    armed_next = armed ? !above : below;
  end

  assign status.out_free = !out_valid || out_ready;

  // Arithmetic working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax   <= in_data[AW-1:0];
      ay   <= in_data[2*AW-1:AW];
      az   <= in_data[3*AW-1:2*AW];
      rem  <= '0;
      res  <= '0;
      bitw <= psd_pkg::RootBitInit;
    end
    if (cmd.square) begin
      rem <= rem + sq[psd_pkg::RootW-1:0];
    end
    if (cmd.root) begin
      if (take) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitw;
      end else begin
        res <= res >> 1;
      end
      bitw <= bitw >> 2;
    end
    if (cmd.fsum) begin
      fsum <= fsum_next;
    end
    if (cmd.fmul) begin
      prod <= fsum * psd_pkg::RecipTen;
    end
  end

  // Detector state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= psd_pkg::LevelReset;
      thr       <= psd_pkg::LevelReset;
      wmax      <= psd_pkg::LevelReset;
      wmin      <= psd_pkg::LevelReset;
      wcount    <= '0;
      gap       <= '0;
      armed     <= 1'b1;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.level) begin
        level <= prod[psd_pkg::RecipSh +: LW];
      end
      if (cmd.window) begin
        wmax <= wmax_next;
        wmin <= wmin_next;
        if (wcount_inc >= window_len) begin
          thr    <= mid_sum[LW:1];
          wcount <= '0;
        end else begin
          wcount <= wcount_inc;
        end
      end
      if (cmd.decide) begin
        out_valid <= 1'b1;
        gap       <= gap_next;
        total     <= total_next;
        armed     <= armed_next;
        out_data  <= {7'd0, thr[LW-1:8], level[LW-1:8], step_hit, total_next};
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/pedometer_step_detector_top.sv -----
// ----------------------------------------------------------------------------
// pedometer_step_detector_top
// A result is registered once its sample has passed the square, root,
// filter, window and decision steps. A new sample waits until the last
// is through; the sixteen root iterations and three squaring passes set
// that pace. The result register lets the next sample in while a result
// waits; a result stalled longer than the work stalls the next one.
// Reset (rst, synchronous) restores the level, threshold and window to 9.8
// m/s^2, clears the counters, arms the detector and reloads the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pedometer_step_detector_top (
  input  wire                            clk,
  input  wire                            rst,
  // Sample stream.
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0: accel_x[15:0], accel_y[15:0], accel_z[15:0].
  input  wire [psd_pkg::InDataW-1:0]     s_axis_tdata,
  // Result stream.
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // Fields from bit 0: total_steps[31:0], step_seen, smoothed_out[15:0],
  // threshold_out[15:0], seven zero bits.
  output logic [psd_pkg::OutDataW-1:0]   m_axis_tdata,
  // Configuration write channel.
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [psd_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire [psd_pkg::CfgDataW-1:0]    cfg_data
);

  psd_pkg::psd_cmd_t          cmd;
  psd_pkg::psd_status_t       status;
  logic [psd_pkg::WinW-1:0]   window_len;
  logic [psd_pkg::GapW-1:0]   min_step_gap;
  logic [psd_pkg::HystW-1:0]  hysteresis;

  assign cfg_ready = 1'b1;

  // Configuration registers; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len   <= psd_pkg::WindowLenReset;
      min_step_gap <= psd_pkg::MinStepGapReset;
      hysteresis   <= psd_pkg::HysteresisReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        psd_pkg::CfgWindowLen:  window_len   <= cfg_data[psd_pkg::WinW-1:0];
        psd_pkg::CfgMinStepGap: min_step_gap <= cfg_data[psd_pkg::GapW-1:0];
        psd_pkg::CfgHysteresis: hysteresis   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  psd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and detector state.
  psd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_data      (s_axis_tdata),
    .window_len   (window_len),
    .min_step_gap (min_step_gap),
    .hysteresis   (hysteresis),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_data     (m_axis_tdata)
  );

endmodule

`default_nettype wire
